@@ hdl/at_response_parser_defines.svh @@
// assertion macros for the at response parser checker
// no dependencies
`ifndef AT_RESPONSE_PARSER_DEFINES_SVH
`define AT_RESPONSE_PARSER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ATRSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("at_response_parser check failed");

// next-cycle implication, disabled in reset
`define ATRSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("at_response_parser check failed");

`endif

@@ hdl/atrsp_pkg.sv @@
// types, constants and helpers of the at response parser
// no dependencies
package atrsp_pkg;

    localparam int MAX_LINES    = 8;
    localparam int MAX_LINE_LEN = 64;
    localparam int LINE_W       = 4;
    localparam int SLOT_W       = 3;
    localparam int COL_W        = 6;
    localparam int SNUM_W       = 5;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_PLUS = 8'h2B;

    localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(MAX_LINES);
    localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(MAX_LINE_LEN - 1);

    typedef enum logic [2:0] {
        ST_CONSUMED  = 3'd0,
        ST_REJECT    = 3'd1,
        ST_OK_DONE   = 3'd2,
        ST_AFTER_OK  = 3'd3,
        ST_AFTER_ERR = 3'd4,
        ST_OVERFLOW  = 3'd5
    } t_status;

    typedef enum logic [18:0] {
        P_CR0   = 19'b0000000000000000001,
        P_LF0   = 19'b0000000000000000010,
        P_HEAD  = 19'b0000000000000000100,
        P_OK_K  = 19'b0000000000000001000,
        P_OK_CR = 19'b0000000000000010000,
        P_OK_LF = 19'b0000000000000100000,
        P_OK_TL = 19'b0000000000001000000,
        P_E_R1  = 19'b0000000000010000000,
        P_E_R2  = 19'b0000000000100000000,
        P_E_O   = 19'b0000000001000000000,
        P_E_R3  = 19'b0000000010000000000,
        P_E_CR  = 19'b0000000100000000000,
        P_E_LF  = 19'b0000001000000000000,
        P_E_TL  = 19'b0000010000000000000,
        P_TEXT  = 19'b0000100000000000000,
        P_T_LF  = 19'b0001000000000000000,
        P_T_NX  = 19'b0010000000000000000,
        P_T_CR  = 19'b0100000000000000000,
        P_T_HD  = 19'b1000000000000000000
    } t_pstate;

    typedef struct packed {
        t_pstate           pstate;
        logic [LINE_W-1:0] line_total;
        logic [COL_W-1:0]  column_index;
    } t_ctx;

    // packed so that status lands in the lowest bits
    typedef struct packed {
        logic [7:0]        store_byte;
        logic [COL_W-1:0]  store_col;
        logic [SLOT_W-1:0] store_line;
        logic              store_write;
        logic [SNUM_W-1:0] reject_state;
        logic [LINE_W-1:0] lines_done;
        logic              ok_flag;
        t_status           status;
    } t_result;

    function automatic logic [SNUM_W-1:0] state_num(input t_pstate s);
        logic [SNUM_W-1:0] n;
        n = '0;
        unique case (s)
            P_CR0:   n = 5'd1;
            P_LF0:   n = 5'd2;
            P_HEAD:  n = 5'd3;
            P_OK_K:  n = 5'd4;
            P_OK_CR: n = 5'd5;
            P_OK_LF: n = 5'd6;
            P_OK_TL: n = 5'd7;
            P_E_R1:  n = 5'd8;
            P_E_R2:  n = 5'd9;
            P_E_O:   n = 5'd10;
            P_E_R3:  n = 5'd11;
            P_E_CR:  n = 5'd12;
            P_E_LF:  n = 5'd13;
            P_E_TL:  n = 5'd14;
            P_TEXT:  n = 5'd15;
            P_T_LF:  n = 5'd17;
            P_T_NX:  n = 5'd18;
            P_T_CR:  n = 5'd19;
            P_T_HD:  n = 5'd20;
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

@@ hdl/atrsp_next.sv @@
// next parser context and result for one received byte
// depends on atrsp_pkg
module atrsp_next (
    input  logic [7:0]        i_byte,
    input  atrsp_pkg::t_ctx   i_ctx,
    output atrsp_pkg::t_ctx   o_ctx,
    output atrsp_pkg::t_result o_res
);

    logic                          fail;
    logic                          count;
    logic [atrsp_pkg::LINE_W-1:0]  counted;

    assign counted = (i_ctx.line_total < atrsp_pkg::LINE_LIMIT) ?
                     i_ctx.line_total + 1'b1 : i_ctx.line_total;

    always_comb begin
        o_ctx = i_ctx;
        fail  = 1'b0;
        count = 1'b0;
        o_res = '0;
        o_res.status = atrsp_pkg::ST_CONSUMED;
        unique case (i_ctx.pstate)
            atrsp_pkg::P_CR0: begin
                if (i_byte == atrsp_pkg::CH_CR) o_ctx.pstate = atrsp_pkg::P_LF0;
                else fail = 1'b1;
            end
            atrsp_pkg::P_LF0: begin
                if (i_byte == atrsp_pkg::CH_LF) o_ctx.pstate = atrsp_pkg::P_HEAD;
                else fail = 1'b1;
            end
            atrsp_pkg::P_HEAD: begin
                priority if (i_byte == atrsp_pkg::CH_O) o_ctx.pstate = atrsp_pkg::P_OK_K;
                else if (i_byte == atrsp_pkg::CH_E) o_ctx.pstate = atrsp_pkg::P_E_R1;
                else if (i_byte == atrsp_pkg::CH_PLUS) o_ctx.pstate = atrsp_pkg::P_TEXT;
                else fail = 1'b1;
            end
            atrsp_pkg::P_OK_K: begin
                if (i_byte == atrsp_pkg::CH_K) o_ctx.pstate = atrsp_pkg::P_OK_CR;
                else fail = 1'b1;
            end
            atrsp_pkg::P_OK_CR: begin
                if (i_byte == atrsp_pkg::CH_CR) o_ctx.pstate = atrsp_pkg::P_OK_LF;
                else fail = 1'b1;
            end
            atrsp_pkg::P_OK_LF: begin
                if (i_byte == atrsp_pkg::CH_LF) begin
                    o_ctx.pstate  = atrsp_pkg::P_OK_TL;
                    o_res.ok_flag = 1'b1;
                    count         = 1'b1;
                    o_res.status  = atrsp_pkg::ST_OK_DONE;
                end else begin
                    fail = 1'b1;
                end
            end
            atrsp_pkg::P_OK_TL: begin
                o_ctx.pstate = atrsp_pkg::P_CR0;
                o_res.status = atrsp_pkg::ST_AFTER_OK;
            end
            atrsp_pkg::P_E_R1: begin
                if (i_byte == atrsp_pkg::CH_R) o_ctx.pstate = atrsp_pkg::P_E_R2;
                else fail = 1'b1;
            end
            atrsp_pkg::P_E_R2: begin
                if (i_byte == atrsp_pkg::CH_R) o_ctx.pstate = atrsp_pkg::P_E_O;
                else fail = 1'b1;
            end
            atrsp_pkg::P_E_O: begin
                if (i_byte == atrsp_pkg::CH_O) o_ctx.pstate = atrsp_pkg::P_E_R3;
                else fail = 1'b1;
            end
            atrsp_pkg::P_E_R3: begin
                if (i_byte == atrsp_pkg::CH_R) begin
                    o_ctx.pstate     = atrsp_pkg::P_E_CR;
                    o_ctx.line_total = '0;
                end else begin
                    fail = 1'b1;
                end
            end
            atrsp_pkg::P_E_CR: begin
                if (i_byte == atrsp_pkg::CH_CR) o_ctx.pstate = atrsp_pkg::P_E_LF;
                else fail = 1'b1;
            end
            atrsp_pkg::P_E_LF: begin
                if (i_byte == atrsp_pkg::CH_LF) o_ctx.pstate = atrsp_pkg::P_E_TL;
                else fail = 1'b1;
            end
            atrsp_pkg::P_E_TL: begin
                o_ctx.pstate = atrsp_pkg::P_CR0;
                o_res.status = atrsp_pkg::ST_AFTER_ERR;
            end
            atrsp_pkg::P_TEXT: begin
                priority if (i_byte != atrsp_pkg::CH_CR) begin
                    if (i_ctx.line_total >= atrsp_pkg::LINE_LIMIT ||
                        i_ctx.column_index >= atrsp_pkg::COL_LIMIT) begin
                        o_res.status = atrsp_pkg::ST_OVERFLOW;
                    end else begin
                        o_res.store_write  = 1'b1;
                        o_res.store_line   = i_ctx.line_total[atrsp_pkg::SLOT_W-1:0];
                        o_res.store_col    = i_ctx.column_index;
                        o_res.store_byte   = i_byte;
                        o_ctx.column_index = i_ctx.column_index + 1'b1;
                    end
                end else if (i_ctx.column_index != '0) begin
                    o_res.store_write  = 1'b1;
                    o_res.store_line   = i_ctx.line_total[atrsp_pkg::SLOT_W-1:0];
                    o_res.store_col    = i_ctx.column_index;
                    o_ctx.column_index = '0;
                    o_ctx.pstate       = atrsp_pkg::P_T_LF;
                end else begin
                    fail = 1'b1;
                end
            end
            atrsp_pkg::P_T_LF: begin
                if (i_byte == atrsp_pkg::CH_LF) begin
                    count         = 1'b1;
                    o_res.ok_flag = 1'b1;
                    o_ctx.pstate  = atrsp_pkg::P_T_NX;
                end else begin
                    fail = 1'b1;
                end
            end
            atrsp_pkg::P_T_NX: begin
                priority if (i_byte == atrsp_pkg::CH_PLUS) o_ctx.pstate = atrsp_pkg::P_TEXT;
                else if (i_byte == atrsp_pkg::CH_CR) o_ctx.pstate = atrsp_pkg::P_T_CR;
                else fail = 1'b1;
            end
            atrsp_pkg::P_T_CR: begin
                if (i_byte == atrsp_pkg::CH_LF) o_ctx.pstate = atrsp_pkg::P_T_HD;
                else fail = 1'b1;
            end
            atrsp_pkg::P_T_HD: begin
                priority if (i_byte == atrsp_pkg::CH_O) o_ctx.pstate = atrsp_pkg::P_OK_K;
                else if (i_byte == atrsp_pkg::CH_E) o_ctx.pstate = atrsp_pkg::P_E_R1;
                else fail = 1'b1;
            end
            default: begin
                o_ctx.pstate = atrsp_pkg::P_CR0;
            end
        endcase

        if (count) begin
            o_ctx.line_total = counted;
        end

        // a rejected byte leaves the whole context untouched
        if (fail) begin
            o_ctx              = i_ctx;
            o_res              = '0;
            o_res.status       = atrsp_pkg::ST_REJECT;
            o_res.reject_state = atrsp_pkg::state_num(i_ctx.pstate);
        end

        o_res.lines_done = o_ctx.line_total;
    end

endmodule

@@ hdl/at_response_parser.sv @@
// at response parser top level: input register, parse step, result register
// depends on atrsp_pkg and atrsp_next
//
// channel   dir  width  fields (lsb first)
// s_axis    in   8      byte_in
// m_axis    out  32     status, ok_flag, lines_done, reject_state, store_write,
//                       store_line, store_col, store_byte, one pad bit
//
// one byte per cycle sustained while the output is not stalled; a byte moves
// from the input register into the result register, which drives the output
// the parse context is updated when a byte moves into the result register
// a stalled result holds while the input register still takes one more byte
// synchronous active-low reset returns to awaiting the first cr, count zero
module at_response_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // byte_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // status, ok_flag, lines_done, reject_state,
                                     // store_write, store_line, store_col, store_byte
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    atrsp_pkg::t_result  r_res;
    atrsp_pkg::t_ctx     r_ctx;

    atrsp_pkg::t_ctx     n_ctx;
    atrsp_pkg::t_result  n_res;

    logic out_free;
    logic advance;
    logic take;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || advance;
    assign take       = i_s_tvalid && o_s_tready;

    atrsp_next u_next (
        .i_byte (r_in_byte),
        .i_ctx  (r_ctx),
        .o_ctx  (n_ctx),
        .o_res  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctx.pstate       <= atrsp_pkg::P_CR0;
            r_ctx.line_total   <= '0;
            r_ctx.column_index <= '0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctx       <= n_ctx;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte <= i_s_tdata;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_res};

endmodule

@@ hdl/atrsp_checker.sv @@
// port-level checks of the at response parser, bound to the top level
// depends on atrsp_pkg and at_response_parser_defines.svh
`include "at_response_parser_defines.svh"

module atrsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    atrsp_pkg::t_result res;
    assign res = o_m_tdata[30:0];

    `ATRSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `ATRSP_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_m_tvalid)
    `ATRSP_ASSERT_NOW(a_write_plain, i_clk, i_rst_n, o_m_tvalid && res.store_write, res.status == atrsp_pkg::ST_CONSUMED && !res.ok_flag && res.reject_state == '0)
    `ATRSP_ASSERT_NOW(a_reject_info, i_clk, i_rst_n, o_m_tvalid && res.status == atrsp_pkg::ST_REJECT, res.reject_state != '0 && !res.store_write && !res.ok_flag)

endmodule

bind at_response_parser atrsp_checker u_atrsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
